// ===== hdl/bbs_pkg.sv =====
// Package for the bouncing ball step block: sequencer states, register
// indexes, fixed field widths and reset values.
// No dependencies.
package bbs_pkg;

    // Fraction bits of every fixed-point word and factor
    localparam int FRAC_BITS = 16;

    // Fixed register and field widths
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int REST_W      = 18;
    localparam int FRIC_W      = 17;
    localparam int RADIUS_W    = 17;
    localparam int STEP_W      = 16;
    localparam int HITS_W      = 3;
    // Signed width of the second multiplier operand (negated restitution)
    localparam int MUL_B_W     = REST_W + 1;

    // Register reset values
    localparam logic signed [CFG_DATA_W-1:0] GRAVITY_Y_RST   = -24'sd642253;
    localparam logic        [REST_W-1:0]     RESTITUTION_RST = 18'd52429;
    localparam logic        [FRIC_W-1:0]     FRICTION_RST    = 17'd64225;
    localparam logic        [RADIUS_W-1:0]   BALL_RADIUS_RST = 17'd6554;
    localparam logic signed [CFG_DATA_W-1:0] START_POS_X_RST = -24'sd52429;
    localparam logic signed [CFG_DATA_W-1:0] START_POS_Y_RST = 24'sd19661;
    localparam logic signed [CFG_DATA_W-1:0] START_VEL_X_RST = 24'sd655360;
    localparam logic signed [CFG_DATA_W-1:0] START_VEL_Y_RST = 24'sd0;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GRAVITY_Y   = 3'd0,
        CFG_RESTITUTION = 3'd1,
        CFG_FRICTION    = 3'd2,
        CFG_BALL_RADIUS = 3'd3,
        CFG_START_POS_X = 3'd4,
        CFG_START_POS_Y = 3'd5,
        CFG_START_VEL_X = 3'd6,
        CFG_START_VEL_Y = 3'd7
    } cfg_index_t;

    // Wall bits of the hit mask
    localparam int HIT_RIGHT = 0;
    localparam int HIT_LEFT  = 1;
    localparam int HIT_FLOOR = 2;

    // Sequencer states: MUL, WALL and FLOOR issue a product, RND rounds it, ADD/SET commits
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_VY,
        ST_RND_VY,
        ST_ADD_VY,
        ST_MUL_PX,
        ST_RND_PX,
        ST_ADD_PX,
        ST_MUL_PY,
        ST_RND_PY,
        ST_ADD_PY,
        ST_WALL_R,
        ST_RND_R,
        ST_SET_R,
        ST_WALL_L,
        ST_RND_L,
        ST_SET_L,
        ST_FLOOR,
        ST_RND_FY,
        ST_SET_FY,
        ST_MUL_FX,
        ST_RND_FX,
        ST_SET_FX,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/bouncing_ball_step_top.sv =====
// Bouncing ball step: one semi-implicit Euler step with wall bounces per transfer,
// built around one shared multiplier under a small sequencer.
// Depends on bbs_pkg.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  in       | in_valid / in_stall    | restart, step_size
//  out      | out_valid / out_stall  | pos_x, pos_y, vel_x, vel_y, wall_hits
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data (always ready)
//
// A step item runs the gravity, x and y products, a bounce product per wall
// or floor bounce and a friction product on floor contact; a restart item
// skips them. Every product goes through the single multiplier, then a rounding
// stage, then the commit, so the products of one step run one after another.
// Reset loads the register defaults and the saturated start state; no sweep.
// A stalled result waits in the output register while the next item is taken.
module bouncing_ball_step_top #(
    parameter int WORD_WIDTH = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // input item channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   restart,
    input  logic [bbs_pkg::STEP_W-1:0]             step_size,
    // result channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [WORD_WIDTH-1:0]           pos_x,
    output logic signed [WORD_WIDTH-1:0]           pos_y,
    output logic signed [WORD_WIDTH-1:0]           vel_x,
    output logic signed [WORD_WIDTH-1:0]           vel_y,
    output logic [bbs_pkg::HITS_W-1:0]             wall_hits,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bbs_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [bbs_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int FRAC = bbs_pkg::FRAC_BITS;
    // multiplier A operand: state word or gravity, whichever is wider
    localparam int AW = (WORD_WIDTH > bbs_pkg::CFG_DATA_W) ? WORD_WIDTH
                                                            : bbs_pkg::CFG_DATA_W;
    localparam int PW = AW + bbs_pkg::MUL_B_W;
    // common width for rounding results, sums and wall compares
    localparam int SW = PW + 1 - FRAC;

    localparam logic signed [SW-1:0] W_MAX =
        {{(SW-WORD_WIDTH+1){1'b0}}, {(WORD_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] W_MIN =
        {{(SW-WORD_WIDTH+1){1'b1}}, {(WORD_WIDTH-1){1'b0}}};
    localparam logic signed [SW-1:0] ONE_S =
        {{(SW-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};
    localparam logic signed [PW:0] HALF_P =
        {{(PW-FRAC+1){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

    // Saturate a wide value to the word range
    function automatic logic signed [WORD_WIDTH-1:0] sat_w(input logic signed [SW-1:0] v);
        logic signed [WORD_WIDTH-1:0] r;
        if (v > W_MAX)
        begin
            r = W_MAX[WORD_WIDTH-1:0];
        end
        else if (v < W_MIN)
        begin
            r = W_MIN[WORD_WIDTH-1:0];
        end
        else
        begin
            r = v[WORD_WIDTH-1:0];
        end
        return r;
    endfunction

    // Configuration registers
    logic signed [bbs_pkg::CFG_DATA_W-1:0] gravity_y_reg;
    logic        [bbs_pkg::REST_W-1:0]     restitution_reg;
    logic        [bbs_pkg::FRIC_W-1:0]     friction_reg;
    logic        [bbs_pkg::RADIUS_W-1:0]   ball_radius_reg;
    logic signed [bbs_pkg::CFG_DATA_W-1:0] start_pos_x_reg;
    logic signed [bbs_pkg::CFG_DATA_W-1:0] start_pos_y_reg;
    logic signed [bbs_pkg::CFG_DATA_W-1:0] start_vel_x_reg;
    logic signed [bbs_pkg::CFG_DATA_W-1:0] start_vel_y_reg;

    // Control and ball state
    bbs_pkg::state_t state_reg, state_next;
    logic signed [WORD_WIDTH-1:0] ball_pos_x_reg, ball_pos_x_next;
    logic signed [WORD_WIDTH-1:0] ball_pos_y_reg, ball_pos_y_next;
    logic signed [WORD_WIDTH-1:0] ball_vel_x_reg, ball_vel_x_next;
    logic signed [WORD_WIDTH-1:0] ball_vel_y_reg, ball_vel_y_next;
    logic [bbs_pkg::HITS_W-1:0]   hits_reg, hits_next;
    logic                         out_valid_reg, out_valid_next;

    // Datapath registers
    logic [bbs_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                         bounce_reg, bounce_next;
    logic signed [PW-1:0]         prod_reg, prod_next;
    logic signed [WORD_WIDTH-1:0] mq_reg, mq_next;
    logic signed [WORD_WIDTH-1:0] pos_x_reg, pos_x_next;
    logic signed [WORD_WIDTH-1:0] pos_y_reg, pos_y_next;
    logic signed [WORD_WIDTH-1:0] vel_x_reg, vel_x_next;
    logic signed [WORD_WIDTH-1:0] vel_y_reg, vel_y_next;
    logic [bbs_pkg::HITS_W-1:0]   wall_hits_reg, wall_hits_next;

    // Shared multiplier operands and helper values
    logic signed [AW-1:0]                mul_a;
    logic signed [bbs_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [bbs_pkg::MUL_B_W-1:0]  dt_s;
    logic signed [bbs_pkg::MUL_B_W-1:0]  neg_rest_s;
    logic signed [bbs_pkg::MUL_B_W-1:0]  fric_s;
    logic signed [PW:0]                  rnd_sum;
    logic signed [SW-1:0]                rnd_val;
    logic signed [SW-1:0]                rad_s;
    logic signed [SW-1:0]                px_s;
    logic signed [SW-1:0]                py_s;
    logic                                hit_right;
    logic                                hit_left;
    logic                                hit_floor;
    logic                                in_xfer;
    logic                                out_load;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != bbs_pkg::ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_load  = (state_reg == bbs_pkg::ST_DONE) && (!out_valid_reg || !out_stall);

    // Factor operands of the multiplier
    assign dt_s       = $signed({3'b000, step_reg});
    assign neg_rest_s = -$signed({1'b0, restitution_reg});
    assign fric_s     = $signed({2'b00, friction_reg});

    // Round half up to 16 fraction bits
    assign rnd_sum = $signed({prod_reg[PW-1], prod_reg}) + HALF_P;
    assign rnd_val = rnd_sum[PW:FRAC];

    // Wall tests on exact wide values
    assign rad_s     = $signed(SW'(ball_radius_reg));
    assign px_s      = SW'(ball_pos_x_reg);
    assign py_s      = SW'(ball_pos_y_reg);
    assign hit_right = (ONE_S - px_s) <= rad_s;
    assign hit_left  = px_s <= (rad_s - ONE_S);
    assign hit_floor = py_s <= (rad_s - ONE_S);

    // Sequencer: next state, operand select and register updates
    always_comb
    begin
        state_next      = state_reg;
        ball_pos_x_next = ball_pos_x_reg;
        ball_pos_y_next = ball_pos_y_reg;
        ball_vel_x_next = ball_vel_x_reg;
        ball_vel_y_next = ball_vel_y_reg;
        hits_next       = hits_reg;
        step_next       = step_reg;
        bounce_next     = bounce_reg;
        mq_next         = sat_w(rnd_val);
        mul_a           = AW'(ball_vel_x_reg);
        mul_b           = dt_s;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        vel_x_next      = vel_x_reg;
        vel_y_next      = vel_y_reg;
        wall_hits_next  = wall_hits_reg;

        unique case (state_reg)
            bbs_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    step_next = step_size;
                    hits_next = '0;
                    if (restart)
                    begin
                        ball_pos_x_next = sat_w(SW'(start_pos_x_reg));
                        ball_pos_y_next = sat_w(SW'(start_pos_y_reg));
                        ball_vel_x_next = sat_w(SW'(start_vel_x_reg));
                        ball_vel_y_next = sat_w(SW'(start_vel_y_reg));
                        state_next      = bbs_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = bbs_pkg::ST_MUL_VY;
                    end
                end
            end
            bbs_pkg::ST_MUL_VY:
            begin
                mul_a      = AW'(gravity_y_reg);
                mul_b      = dt_s;
                state_next = bbs_pkg::ST_RND_VY;
            end
            bbs_pkg::ST_RND_VY:
            begin
                state_next = bbs_pkg::ST_ADD_VY;
            end
            bbs_pkg::ST_ADD_VY:
            begin
                ball_vel_y_next = sat_w(SW'(ball_vel_y_reg) + SW'(mq_reg));
                state_next      = bbs_pkg::ST_MUL_PX;
            end
            bbs_pkg::ST_MUL_PX:
            begin
                mul_a      = AW'(ball_vel_x_reg);
                mul_b      = dt_s;
                state_next = bbs_pkg::ST_RND_PX;
            end
            bbs_pkg::ST_RND_PX:
            begin
                state_next = bbs_pkg::ST_ADD_PX;
            end
            bbs_pkg::ST_ADD_PX:
            begin
                ball_pos_x_next = sat_w(SW'(ball_pos_x_reg) + SW'(mq_reg));
                state_next      = bbs_pkg::ST_MUL_PY;
            end
            bbs_pkg::ST_MUL_PY:
            begin
                mul_a      = AW'(ball_vel_y_reg);
                mul_b      = dt_s;
                state_next = bbs_pkg::ST_RND_PY;
            end
            bbs_pkg::ST_RND_PY:
            begin
                state_next = bbs_pkg::ST_ADD_PY;
            end
            bbs_pkg::ST_ADD_PY:
            begin
                ball_pos_y_next = sat_w(SW'(ball_pos_y_reg) + SW'(mq_reg));
                state_next      = bbs_pkg::ST_WALL_R;
            end
            // Right wall: clamp, and bounce when moving right or still
            bbs_pkg::ST_WALL_R:
            begin
                mul_a      = AW'(ball_vel_x_reg);
                mul_b      = neg_rest_s;
                state_next = bbs_pkg::ST_WALL_L;
                if (hit_right)
                begin
                    hits_next[bbs_pkg::HIT_RIGHT] = 1'b1;
                    ball_pos_x_next = sat_w(ONE_S - rad_s);
                    if (!ball_vel_x_reg[WORD_WIDTH-1])
                    begin
                        state_next = bbs_pkg::ST_RND_R;
                    end
                end
            end
            bbs_pkg::ST_RND_R:
            begin
                state_next = bbs_pkg::ST_SET_R;
            end
            bbs_pkg::ST_SET_R:
            begin
                ball_vel_x_next = mq_reg;
                state_next      = bbs_pkg::ST_WALL_L;
            end
            // Left wall: clamp, and bounce when moving left or still
            bbs_pkg::ST_WALL_L:
            begin
                mul_a      = AW'(ball_vel_x_reg);
                mul_b      = neg_rest_s;
                state_next = bbs_pkg::ST_FLOOR;
                if (hit_left)
                begin
                    hits_next[bbs_pkg::HIT_LEFT] = 1'b1;
                    ball_pos_x_next = sat_w(rad_s - ONE_S);
                    if (ball_vel_x_reg[WORD_WIDTH-1] || (ball_vel_x_reg == '0))
                    begin
                        state_next = bbs_pkg::ST_RND_L;
                    end
                end
            end
            bbs_pkg::ST_RND_L:
            begin
                state_next = bbs_pkg::ST_SET_L;
            end
            bbs_pkg::ST_SET_L:
            begin
                ball_vel_x_next = mq_reg;
                state_next      = bbs_pkg::ST_FLOOR;
            end
            // Floor: clamp, bounce when falling or still, then friction
            bbs_pkg::ST_FLOOR:
            begin
                mul_a      = AW'(ball_vel_y_reg);
                mul_b      = neg_rest_s;
                state_next = bbs_pkg::ST_DONE;
                if (hit_floor)
                begin
                    hits_next[bbs_pkg::HIT_FLOOR] = 1'b1;
                    ball_pos_y_next = sat_w(rad_s - ONE_S);
                    bounce_next     = ball_vel_y_reg[WORD_WIDTH-1] || (ball_vel_y_reg == '0);
                    if (ball_vel_y_reg[WORD_WIDTH-1] || (ball_vel_y_reg == '0))
                    begin
                        state_next = bbs_pkg::ST_RND_FY;
                    end
                    else
                    begin
                        state_next = bbs_pkg::ST_MUL_FX;
                    end
                end
            end
            bbs_pkg::ST_RND_FY:
            begin
                state_next = bbs_pkg::ST_SET_FY;
            end
            bbs_pkg::ST_SET_FY:
            begin
                ball_vel_y_next = mq_reg;
                state_next      = bbs_pkg::ST_MUL_FX;
            end
            bbs_pkg::ST_MUL_FX:
            begin
                mul_a      = AW'(ball_vel_x_reg);
                mul_b      = fric_s;
                state_next = bbs_pkg::ST_RND_FX;
            end
            bbs_pkg::ST_RND_FX:
            begin
                state_next = bbs_pkg::ST_SET_FX;
            end
            bbs_pkg::ST_SET_FX:
            begin
                ball_vel_x_next = mq_reg;
                state_next      = bbs_pkg::ST_DONE;
            end
            // Hand the new state to the output register once it is free
            bbs_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    pos_x_next     = ball_pos_x_reg;
                    pos_y_next     = ball_pos_y_reg;
                    vel_x_next     = ball_vel_x_reg;
                    vel_y_next     = ball_vel_y_reg;
                    wall_hits_next = hits_reg;
                    state_next     = bbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bbs_pkg::ST_IDLE;
            end
        endcase

        prod_next = PW'(mul_a) * PW'(mul_b);

        // Output valid: set on load, drop on transfer
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Sequencer state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bbs_pkg::ST_IDLE;
            ball_pos_x_reg <= sat_w(SW'(bbs_pkg::START_POS_X_RST));
            ball_pos_y_reg <= sat_w(SW'(bbs_pkg::START_POS_Y_RST));
            ball_vel_x_reg <= sat_w(SW'(bbs_pkg::START_VEL_X_RST));
            ball_vel_y_reg <= sat_w(SW'(bbs_pkg::START_VEL_Y_RST));
            hits_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ball_pos_x_reg <= ball_pos_x_next;
            ball_pos_y_reg <= ball_pos_y_next;
            ball_vel_x_reg <= ball_vel_x_next;
            ball_vel_y_reg <= ball_vel_y_next;
            hits_reg       <= hits_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_y_reg   <= bbs_pkg::GRAVITY_Y_RST;
            restitution_reg <= bbs_pkg::RESTITUTION_RST;
            friction_reg    <= bbs_pkg::FRICTION_RST;
            ball_radius_reg <= bbs_pkg::BALL_RADIUS_RST;
            start_pos_x_reg <= bbs_pkg::START_POS_X_RST;
            start_pos_y_reg <= bbs_pkg::START_POS_Y_RST;
            start_vel_x_reg <= bbs_pkg::START_VEL_X_RST;
            start_vel_y_reg <= bbs_pkg::START_VEL_Y_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (bbs_pkg::cfg_index_t'(cfg_index))
                bbs_pkg::CFG_GRAVITY_Y:   gravity_y_reg   <= $signed(cfg_data);
                bbs_pkg::CFG_RESTITUTION: restitution_reg <= cfg_data[bbs_pkg::REST_W-1:0];
                bbs_pkg::CFG_FRICTION:    friction_reg    <= cfg_data[bbs_pkg::FRIC_W-1:0];
                bbs_pkg::CFG_BALL_RADIUS: ball_radius_reg <= cfg_data[bbs_pkg::RADIUS_W-1:0];
                bbs_pkg::CFG_START_POS_X: start_pos_x_reg <= $signed(cfg_data);
                bbs_pkg::CFG_START_POS_Y: start_pos_y_reg <= $signed(cfg_data);
                bbs_pkg::CFG_START_VEL_X: start_vel_x_reg <= $signed(cfg_data);
                bbs_pkg::CFG_START_VEL_Y: start_vel_y_reg <= $signed(cfg_data);
                default:                  gravity_y_reg   <= gravity_y_reg;
            endcase
        end
    end

    // Datapath and output payload registers
    always_ff @(posedge clk)
    begin
        step_reg      <= step_next;
        bounce_reg    <= bounce_next;
        prod_reg      <= prod_next;
        mq_reg        <= mq_next;
        pos_x_reg     <= pos_x_next;
        pos_y_reg     <= pos_y_next;
        vel_x_reg     <= vel_x_next;
        vel_y_reg     <= vel_y_next;
        wall_hits_reg <= wall_hits_next;
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign vel_x     = vel_x_reg;
    assign vel_y     = vel_y_reg;
    assign wall_hits = wall_hits_reg;

    // A transfer on the input starts the sequencer at once
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> in_stall)
        else $error("block took an item but did not go busy");

    // A restart item goes straight to the result stage
    a_restart_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && restart) |=> (state_reg == bbs_pkg::ST_DONE))
        else $error("restart item did not skip the step");

    // Friction is only applied after floor contact, and a floor bounce product is
    // only committed when the ball was falling or still
    a_friction_needs_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bbs_pkg::ST_SET_FX) |-> hits_reg[bbs_pkg::HIT_FLOOR])
        else $error("friction applied without floor contact");

    a_floor_bounce_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bbs_pkg::ST_SET_FY) |-> (bounce_reg && hits_reg[bbs_pkg::HIT_FLOOR]))
        else $error("floor bounce without contact");

endmodule

// ===== sim/bouncing_ball_step_top_tb.sv =====
// Self-checking testbench for bouncing_ball_step_top: a table of directed ticks, then
// phases of random ticks under varied register settings, checked against a local predictor.
// Depends on bbs_pkg and the bouncing_ball_step_top RTL.
module bouncing_ball_step_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     WORD_W          = 24;
    localparam longint ONE_Q           = longint'(1) << bbs_pkg::FRAC_BITS;
    localparam longint HALF_Q          = longint'(1) << (bbs_pkg::FRAC_BITS - 1);
    localparam longint WORD_HI         = (longint'(1) << (WORD_W - 1)) - 1;
    localparam longint WORD_LO         = -(longint'(1) << (WORD_W - 1));
    localparam int     PHASES          = 11;
    localparam int     TICKS_PER_PHASE = 68;
    localparam int     HOLD_PHASE      = 5;
    localparam int     CALM_PHASE      = 6;
    localparam int     HOLD_CYCLES     = 300;
    localparam int     SETTLE_CYCLES   = 40;
    localparam int     LIMIT_CYCLES    = 400000;

    typedef struct packed {
        logic signed [WORD_W-1:0]   px;
        logic signed [WORD_W-1:0]   py;
        logic signed [WORD_W-1:0]   vx;
        logic signed [WORD_W-1:0]   vy;
        logic [bbs_pkg::HITS_W-1:0] hits;
    } ball_result_t;

    typedef struct packed {
        logic                       reload;
        logic [bbs_pkg::STEP_W-1:0] dt;
        logic                       known;
        ball_result_t               want;
    } probe_row_t;

    typedef enum {SET_PLAIN, SET_LOW, SET_HIGH, SET_WIDE, SET_WILD, SET_DEFAULT} setting_kind_t;

    // Start state straight after reset, also what any restart shows under default registers
    localparam ball_result_t AT_START =
        '{-24'sd52429, 24'sd19661, 24'sd655360, 24'sd0, 3'b000};
    localparam ball_result_t NO_WANT = '0;

    // Directed ticks under the reset register values
    localparam probe_row_t PROBES [23] = '{
        '{1'b1, 16'hFFFF, 1'b1, AT_START},
        '{1'b0, 16'h0000, 1'b1, AT_START},
        '{1'b0, 16'h0001, 1'b0, NO_WANT},
        '{1'b0, 16'h1000, 1'b0, NO_WANT},
        '{1'b0, 16'h1000, 1'b0, NO_WANT},
        '{1'b0, 16'h1000, 1'b0, NO_WANT},
        '{1'b0, 16'h1000, 1'b0, NO_WANT},
        '{1'b0, 16'h1000, 1'b0, NO_WANT},
        '{1'b0, 16'h1000, 1'b0, NO_WANT},
        '{1'b0, 16'h1000, 1'b0, NO_WANT},
        '{1'b0, 16'h2000, 1'b0, NO_WANT},
        '{1'b0, 16'h2000, 1'b0, NO_WANT},
        '{1'b0, 16'h2000, 1'b0, NO_WANT},
        '{1'b0, 16'h0000, 1'b0, NO_WANT},
        '{1'b0, 16'h2000, 1'b0, NO_WANT},
        '{1'b0, 16'h7FFF, 1'b0, NO_WANT},
        '{1'b0, 16'h8000, 1'b0, NO_WANT},
        '{1'b0, 16'hFFFF, 1'b0, NO_WANT},
        '{1'b1, 16'h0000, 1'b1, AT_START},
        '{1'b0, 16'hFFFF, 1'b0, NO_WANT},
        '{1'b0, 16'hAAAA, 1'b0, NO_WANT},
        '{1'b0, 16'h5555, 1'b0, NO_WANT},
        '{1'b1, 16'h5555, 1'b1, AT_START}
    };

    localparam setting_kind_t PHASE_PLAN [PHASES] = '{
        SET_PLAIN, SET_LOW, SET_HIGH, SET_WIDE, SET_WILD, SET_PLAIN,
        SET_PLAIN, SET_WILD, SET_WIDE, SET_WILD, SET_DEFAULT
    };

    logic                            clk;
    logic                            rst_n      = 1'b0;
    logic                            in_valid   = 1'b0;
    logic                            in_stall;
    logic                            restart    = 1'b0;
    logic [bbs_pkg::STEP_W-1:0]      step_size  = '0;
    logic                            out_valid;
    logic                            out_stall  = 1'b0;
    logic signed [WORD_W-1:0]        pos_x;
    logic signed [WORD_W-1:0]        pos_y;
    logic signed [WORD_W-1:0]        vel_x;
    logic signed [WORD_W-1:0]        vel_y;
    logic [bbs_pkg::HITS_W-1:0]      wall_hits;
    logic                            cfg_valid  = 1'b0;
    logic                            cfg_ready;
    logic [bbs_pkg::CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [bbs_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;

    // Predicted ball state and register copies
    longint ball_x, ball_y, speed_x, speed_y;
    longint grav, bounce, fric, radius;
    longint home_x, home_y, launch_vx, launch_vy;

    ball_result_t want_q [$];
    bit  calm     = 1'b0;
    bit  hold_req = 1'b0;
    int  mismatches    = 0;
    int  ticks_sent    = 0;
    int  restarts_sent = 0;
    int  results_seen  = 0;
    int  wall_contacts = 0;
    int  cycle_count   = 0;

    bouncing_ball_step_top #(
        .WORD_WIDTH (WORD_W)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .restart    (restart),
        .step_size  (step_size),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .wall_hits  (wall_hits),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint sat_word(input longint v);
        if (v > WORD_HI)
            return WORD_HI;
        if (v < WORD_LO)
            return WORD_LO;
        return v;
    endfunction

    // Exact product with a Q.16 factor, round half up, saturate
    function automatic longint mul_round(input longint a, input longint b);
        longint q;
        q = a * b + HALF_Q;
        return sat_word(q >>> bbs_pkg::FRAC_BITS);
    endfunction

    // Advance the predicted ball by one tick and return the result it shows
    function automatic ball_result_t advance_ball(input logic rs,
                                                  input logic [bbs_pkg::STEP_W-1:0] dt);
        ball_result_t               r;
        longint                     t;
        logic [bbs_pkg::HITS_W-1:0] hits;
        hits = '0;
        if (rs)
        begin
            ball_x  = sat_word(home_x);
            ball_y  = sat_word(home_y);
            speed_x = sat_word(launch_vx);
            speed_y = sat_word(launch_vy);
        end
        else
        begin
            t       = longint'(dt);
            speed_y = sat_word(speed_y + mul_round(grav, t));
            ball_x  = sat_word(ball_x + mul_round(speed_x, t));
            ball_y  = sat_word(ball_y + mul_round(speed_y, t));
            // right wall, then left wall, then floor
            if (ONE_Q - ball_x <= radius)
            begin
                hits[bbs_pkg::HIT_RIGHT] = 1'b1;
                ball_x = sat_word(ONE_Q - radius);
                if (speed_x >= 0)
                    speed_x = mul_round(speed_x, -bounce);
            end
            if (ball_x <= -ONE_Q + radius)
            begin
                hits[bbs_pkg::HIT_LEFT] = 1'b1;
                ball_x = sat_word(-ONE_Q + radius);
                if (speed_x <= 0)
                    speed_x = mul_round(speed_x, -bounce);
            end
            if (ball_y <= -ONE_Q + radius)
            begin
                hits[bbs_pkg::HIT_FLOOR] = 1'b1;
                ball_y = sat_word(-ONE_Q + radius);
                if (speed_y <= 0)
                    speed_y = mul_round(speed_y, -bounce);
                speed_x = mul_round(speed_x, fric);
            end
        end
        r.px   = ball_x[WORD_W-1:0];
        r.py   = ball_y[WORD_W-1:0];
        r.vx   = speed_x[WORD_W-1:0];
        r.vy   = speed_y[WORD_W-1:0];
        r.hits = hits;
        return r;
    endfunction

    // Offer one tick, hold it until the transfer, then queue its expected result
    task automatic send_tick(input logic rs, input logic [bbs_pkg::STEP_W-1:0] dt,
                             input logic fixed, input ball_result_t fixed_want);
        ball_result_t want;
        while (!calm && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        restart   <= rs;
        step_size <= dt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = advance_ball(rs, dt);
        want_q.push_back(fixed ? fixed_want : want);
        ticks_sent++;
        if (rs)
            restarts_sent++;
    endtask

    // Write one register and mirror it; valid stays up for a following write
    task automatic cfg_write(input bbs_pkg::cfg_index_t idx,
                             input logic [bbs_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            bbs_pkg::CFG_GRAVITY_Y:   grav      = longint'(signed'(data));
            bbs_pkg::CFG_RESTITUTION: bounce    = longint'(data[bbs_pkg::REST_W-1:0]);
            bbs_pkg::CFG_FRICTION:    fric      = longint'(data[bbs_pkg::FRIC_W-1:0]);
            bbs_pkg::CFG_BALL_RADIUS: radius    = longint'(data[bbs_pkg::RADIUS_W-1:0]);
            bbs_pkg::CFG_START_POS_X: home_x    = longint'(signed'(data));
            bbs_pkg::CFG_START_POS_Y: home_y    = longint'(signed'(data));
            bbs_pkg::CFG_START_VEL_X: launch_vx = longint'(signed'(data));
            bbs_pkg::CFG_START_VEL_Y: launch_vy = longint'(signed'(data));
            default: ;
        endcase
    endtask

    // Drop valid and wait until every queued result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (want_q.size() != 0)
            @(posedge clk);
    endtask

    // Result side: check each transfer, stall at random, and hold off once for a long stretch
    initial
    begin
        ball_result_t got;
        ball_result_t want;
        int           hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got = '{pos_x, pos_y, vel_x, vel_y, wall_hits};
                results_seen++;
                if (got.hits != '0)
                    wall_contacts++;
                if (want_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with nothing expected", results_seen);
                end
                else
                begin
                    want = want_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result %0d mismatch: expected px=%0d py=%0d vx=%0d vy=%0d hits=%b",
                                     results_seen, want.px, want.py, want.vx, want.vy,
                                     want.hits);
                            $display("    got px=%0d py=%0d vx=%0d vy=%0d hits=%b",
                                     got.px, got.py, got.vx, got.vy, got.hits);
                        end
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < 17);
        end
    end

    // Stop a hung run
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("bouncing_ball_step_top_tb: done, errors");
        $finish;
    end

    // Stimulus: directed table, then phases of register settings with random ticks
    initial
    begin
        logic [bbs_pkg::CFG_DATA_W-1:0] setting [8];
        logic                           rs;
        logic [bbs_pkg::STEP_W-1:0]     dt;
        int                             roll;

        grav      = bbs_pkg::GRAVITY_Y_RST;
        bounce    = bbs_pkg::RESTITUTION_RST;
        fric      = bbs_pkg::FRICTION_RST;
        radius    = bbs_pkg::BALL_RADIUS_RST;
        home_x    = bbs_pkg::START_POS_X_RST;
        home_y    = bbs_pkg::START_POS_Y_RST;
        launch_vx = bbs_pkg::START_VEL_X_RST;
        launch_vy = bbs_pkg::START_VEL_Y_RST;
        ball_x    = sat_word(home_x);
        ball_y    = sat_word(home_y);
        speed_x   = sat_word(launch_vx);
        speed_y   = sat_word(launch_vy);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (PROBES[i])
            send_tick(PROBES[i].reload, PROBES[i].dt, PROBES[i].known, PROBES[i].want);
        drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // pick this phase's register values
            case (PHASE_PLAN[phase])
                SET_LOW:
                begin
                    setting[bbs_pkg::CFG_GRAVITY_Y]   = 24'h800000;
                    setting[bbs_pkg::CFG_RESTITUTION] = '0;
                    setting[bbs_pkg::CFG_FRICTION]    = '0;
                    setting[bbs_pkg::CFG_BALL_RADIUS] = '0;
                    setting[bbs_pkg::CFG_START_POS_X] = 24'h800000;
                    setting[bbs_pkg::CFG_START_POS_Y] = 24'h800000;
                    setting[bbs_pkg::CFG_START_VEL_X] = 24'h800000;
                    setting[bbs_pkg::CFG_START_VEL_Y] = 24'h800000;
                end
                SET_HIGH:
                begin
                    setting[bbs_pkg::CFG_GRAVITY_Y]   = 24'h7FFFFF;
                    setting[bbs_pkg::CFG_RESTITUTION] = 24'hFFFFFF;
                    setting[bbs_pkg::CFG_FRICTION]    = 24'hFFFFFF;
                    setting[bbs_pkg::CFG_BALL_RADIUS] = 24'hFFFFFF;
                    setting[bbs_pkg::CFG_START_POS_X] = 24'h7FFFFF;
                    setting[bbs_pkg::CFG_START_POS_Y] = 24'h7FFFFF;
                    setting[bbs_pkg::CFG_START_VEL_X] = 24'h7FFFFF;
                    setting[bbs_pkg::CFG_START_VEL_Y] = 24'h7FFFFF;
                end
                SET_WILD:
                    foreach (setting[i])
                        setting[i] = 24'($urandom);
                SET_DEFAULT:
                begin
                    setting[bbs_pkg::CFG_GRAVITY_Y]   = bbs_pkg::GRAVITY_Y_RST;
                    setting[bbs_pkg::CFG_RESTITUTION] = 24'(bbs_pkg::RESTITUTION_RST);
                    setting[bbs_pkg::CFG_FRICTION]    = 24'(bbs_pkg::FRICTION_RST);
                    setting[bbs_pkg::CFG_BALL_RADIUS] = 24'(bbs_pkg::BALL_RADIUS_RST);
                    setting[bbs_pkg::CFG_START_POS_X] = bbs_pkg::START_POS_X_RST;
                    setting[bbs_pkg::CFG_START_POS_Y] = bbs_pkg::START_POS_Y_RST;
                    setting[bbs_pkg::CFG_START_VEL_X] = bbs_pkg::START_VEL_X_RST;
                    setting[bbs_pkg::CFG_START_VEL_Y] = bbs_pkg::START_VEL_Y_RST;
                end
                default:
                begin
                    // plausible physics in the unit box; a wide ball touches both side walls
                    setting[bbs_pkg::CFG_GRAVITY_Y]   = 24'(-int'($urandom_range(0, 1310720)));
                    setting[bbs_pkg::CFG_RESTITUTION] = 24'($urandom_range(32768, 65536));
                    setting[bbs_pkg::CFG_FRICTION]    = 24'($urandom_range(49152, 65536));
                    setting[bbs_pkg::CFG_BALL_RADIUS] = (PHASE_PLAN[phase] == SET_WIDE)
                                                      ? 24'($urandom_range(65536, 131071))
                                                      : 24'($urandom_range(0, 13107));
                    setting[bbs_pkg::CFG_START_POS_X] =
                        24'(int'($urandom_range(0, 131072)) - 65536);
                    setting[bbs_pkg::CFG_START_POS_Y] =
                        24'(int'($urandom_range(0, 131072)) - 65536);
                    setting[bbs_pkg::CFG_START_VEL_X] =
                        24'(int'($urandom_range(0, 1310720)) - 655360);
                    setting[bbs_pkg::CFG_START_VEL_Y] =
                        24'(int'($urandom_range(0, 1310720)) - 655360);
                end
            endcase

            for (int i = 0; i < 8; i++)
                cfg_write(bbs_pkg::cfg_index_t'(i), setting[i]);
            cfg_valid <= 1'b0;

            calm = (phase == CALM_PHASE);
            if (phase == HOLD_PHASE)
                hold_req = 1'b1;

            // load the new start state, then random ticks with mostly small steps
            send_tick(1'b1, 16'($urandom), 1'b0, NO_WANT);
            repeat (TICKS_PER_PHASE - 1)
            begin
                roll = $urandom_range(99);
                if (roll < 10)
                    dt = '0;
                else if (roll < 18)
                    dt = '1;
                else if (roll < 60)
                    dt = 16'($urandom_range(0, 16'h0800));
                else
                    dt = 16'($urandom);
                rs = ($urandom_range(99) < 4);
                send_tick(rs, dt, 1'b0, NO_WANT);
            end
            drain();
        end

        calm = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d ticks sent (%0d restarts) over %0d register settings", ticks_sent,
                 restarts_sent, PHASES + 1);
        $display("%0d results checked, %0d with a wall contact, %0d mismatches", results_seen,
                 wall_contacts, mismatches);
        if (mismatches == 0 && want_q.size() == 0)
            $display("bouncing_ball_step_top_tb: done, clean");
        else
            $display("bouncing_ball_step_top_tb: done, errors");
        $finish;
    end

endmodule
